>>> rtl/mcpwm_pkg.sv
package mcpwm_pkg;

   localparam int DEFAULT_CHANNELS   = 8;
   localparam int DEFAULT_COUNT_BITS = 32;

   localparam int KIND_BITS     = 2;
   localparam int ADDR_BITS     = 8;
   localparam int DATA_BITS     = 32;
   localparam int OUT_BITS      = 8;
   localparam int WORD_BITS     = ADDR_BITS - 2;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   localparam logic [WORD_BITS-1:0] WORD_GEN_ENABLE = 6'd0;
   localparam logic [WORD_BITS-1:0] WORD_OUT_ENABLE = 6'd1;
   localparam logic [WORD_BITS-1:0] WORD_CHAN_BASE  = 6'd2;

endpackage

>>> rtl/multi_channel_pwm_peripheral.sv
// Multi-channel PWM peripheral. Each request transfer is one timer tick, one register
// write or one register read, selected by req_tuser; every request gives exactly one
// response carrying the read data (zero unless a read) and the channel output levels
// after that request. Register map by byte offset: 0x00 generation enables, 0x04 output
// enables, 0x08+8n period of channel n, 0x0C+8n high time of channel n; unmapped
// offsets read as zero and ignore writes. A request is processed in the cycle it is
// accepted and its response appears on the next cycle unless an older untaken one holds
// the output; one request is taken every cycle while req_tready is high. A two-entry
// response buffer keeps req_tready high while one waits; it drops only when both are full.
module multi_channel_pwm_peripheral #(
   parameter int CHANNELS   = mcpwm_pkg::DEFAULT_CHANNELS,
   parameter int COUNT_BITS = mcpwm_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // address [7:0], write_data [39:8]
   input  logic [mcpwm_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // kind [1:0]
   input  logic [mcpwm_pkg::KIND_BITS-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_data [31:0], pwm_out [39:32]
   output logic [mcpwm_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import mcpwm_pkg::*;

   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LVL_BITS    = (CHANNELS > OUT_BITS) ? CHANNELS : OUT_BITS;

   logic [CHANNELS-1:0]   gen_enable_ff, gen_enable_in;
   logic [CHANNELS-1:0]   out_enable_ff, out_enable_in;
   logic [COUNT_BITS-1:0] period_ff [CHANNELS];
   logic [COUNT_BITS-1:0] period_in [CHANNELS];
   logic [COUNT_BITS-1:0] high_ff   [CHANNELS];
   logic [COUNT_BITS-1:0] high_in   [CHANNELS];
   logic [COUNT_BITS-1:0] phase_ff  [CHANNELS];
   logic [COUNT_BITS-1:0] phase_in  [CHANNELS];

   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] skid_data_ff, skid_data_in;
   logic                     skid_valid_ff, skid_valid_in;

   logic                   accept;
   logic                   take;
   kind_type               kind;
   logic [ADDR_BITS-1:0]   address;
   logic [DATA_BITS-1:0]   write_data;
   logic [WORD_BITS-1:0]   word_sel;
   logic [WORD_BITS-1:0]   word_off;
   logic [WORD_BITS-2:0]   chan_num;
   logic                   chan_hit;
   logic [CH_IDX_BITS-1:0] chan_idx;
   logic                   is_tick;
   logic                   is_write;
   logic                   is_read;
   logic [COUNT_BITS:0]    phase_next;
   logic [DATA_BITS-1:0]   read_data;
   logic [LVL_BITS-1:0]    level_all;
   logic [OUT_BITS-1:0]    pwm_out;
   logic [RSP_DATA_BITS-1:0] result;

   assign accept     = req_tvalid && req_tready;
   assign take       = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign kind       = kind_type'(req_tuser);
   assign address    = req_tdata[ADDR_BITS-1:0];
   assign write_data = req_tdata[ADDR_BITS+DATA_BITS-1:ADDR_BITS];
   assign word_sel   = address[ADDR_BITS-1:2];
   assign word_off   = word_sel - WORD_CHAN_BASE;
   assign chan_num   = word_off[WORD_BITS-1:1];
   assign chan_hit   = (word_sel >= WORD_CHAN_BASE) && (32'(chan_num) < CHANNELS);
   assign chan_idx   = chan_num[CH_IDX_BITS-1:0];

   always_comb begin
      is_tick  = 1'b0;
      is_write = 1'b0;
      is_read  = 1'b0;
      case (kind)
         KIND_TICK:  is_tick  = accept;
         KIND_WRITE: is_write = accept;
         KIND_READ:  is_read  = accept;
         default: begin
         end
      endcase
   end

   always_comb begin
      gen_enable_in = gen_enable_ff;
      out_enable_in = out_enable_ff;
      phase_next    = '0;
      if (is_write && (word_sel == WORD_GEN_ENABLE)) begin
         gen_enable_in = write_data[CHANNELS-1:0];
      end
      if (is_write && (word_sel == WORD_OUT_ENABLE)) begin
         out_enable_in = write_data[CHANNELS-1:0];
      end
      for (int c = 0; c < CHANNELS; c++) begin
         period_in[c] = period_ff[c];
         high_in[c]   = high_ff[c];
         phase_in[c]  = phase_ff[c];
         if (is_write && chan_hit && (chan_num == (WORD_BITS-1)'(c))) begin
            if (word_sel[0] == 1'b0) begin
               period_in[c] = write_data[COUNT_BITS-1:0];
            end else begin
               high_in[c] = write_data[COUNT_BITS-1:0];
            end
         end
         if (!gen_enable_in[c]) begin
            phase_in[c] = '0;
         end else if (is_tick) begin
            phase_next = {1'b0, phase_ff[c]} + 1'b1;
            if (phase_next >= {1'b0, period_ff[c]}) begin
               phase_in[c] = '0;
            end else begin
               phase_in[c] = phase_next[COUNT_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      level_all = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         level_all[c] = gen_enable_in[c] && out_enable_in[c] && (period_in[c] != '0) &&
                        ((phase_in[c] < high_in[c]) || (high_in[c] >= period_in[c]));
      end
      pwm_out = level_all[OUT_BITS-1:0];
   end

   always_comb begin
      read_data = '0;
      if (is_read) begin
         if (word_sel == WORD_GEN_ENABLE) begin
            read_data = DATA_BITS'(gen_enable_ff);
         end else if (word_sel == WORD_OUT_ENABLE) begin
            read_data = DATA_BITS'(out_enable_ff);
         end else if (chan_hit) begin
            if (word_sel[0] == 1'b0) begin
               read_data = DATA_BITS'(period_ff[chan_idx]);
            end else begin
               read_data = DATA_BITS'(high_ff[chan_idx]);
            end
         end
      end
      result = {pwm_out, read_data};
   end

   always_comb begin
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_enable_ff <= '0;
         out_enable_ff <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            period_ff[c] <= '0;
            high_ff[c]   <= '0;
            phase_ff[c]  <= '0;
         end
      end else begin
         gen_enable_ff <= gen_enable_in;
         out_enable_ff <= out_enable_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int c = 0; c < CHANNELS; c++) begin
            period_ff[c] <= period_in[c];
            high_ff[c]   <= high_in[c];
            phase_ff[c]  <= phase_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcpwm_pkg::*;

   localparam int CHANNELS       = DEFAULT_CHANNELS;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;

   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_data;
      logic [OUT_BITS-1:0]  pwm_out;
   } pwm_response_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // address [7:0], write_data [39:8]
   logic [KIND_BITS-1:0]     req_tuser;   // kind [1:0]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // read_data [31:0], pwm_out [39:32]

   logic [CHANNELS-1:0] gen_mask;
   logic [CHANNELS-1:0] oe_mask;
   logic [31:0]         chan_period [CHANNELS];
   logic [31:0]         chan_high   [CHANNELS];
   logic [31:0]         chan_phase  [CHANNELS];

   pwm_response_type pending_responses[$];
   int unsigned      mismatch_count;
   int unsigned      stall_cycles;
   bit               steady;

   multi_channel_pwm_peripheral u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic pwm_response_type predict_pwm_response(logic [KIND_BITS-1:0] kind,
                                                             logic [ADDR_BITS-1:0] address,
                                                             logic [DATA_BITS-1:0] wdata);
      logic [WORD_BITS-1:0] word;
      logic [32:0]          next_phase;
      int                   chan;
      pwm_response_type     rsp;
      word = address[ADDR_BITS-1:2];
      chan = (int'(word) - int'(WORD_CHAN_BASE)) / 2;
      rsp  = '0;
      case (kind)
         KIND_TICK: begin
            for (int n = 0; n < CHANNELS; n++) begin
               if (!gen_mask[n]) begin
                  chan_phase[n] = '0;
               end else begin
                  next_phase = {1'b0, chan_phase[n]} + 33'd1;
                  if (next_phase >= {1'b0, chan_period[n]})
                     next_phase = '0;
                  chan_phase[n] = next_phase[31:0];
               end
            end
         end
         KIND_WRITE: begin
            if (word == WORD_GEN_ENABLE) begin
               gen_mask = wdata[CHANNELS-1:0];
               for (int n = 0; n < CHANNELS; n++)
                  if (!gen_mask[n])
                     chan_phase[n] = '0;
            end else if (word == WORD_OUT_ENABLE) begin
               oe_mask = wdata[CHANNELS-1:0];
            end else if (chan < CHANNELS) begin
               if (word[0] == 1'b0)
                  chan_period[chan] = wdata;
               else
                  chan_high[chan] = wdata;
            end
         end
         KIND_READ: begin
            if (word == WORD_GEN_ENABLE)
               rsp.read_data = DATA_BITS'(gen_mask);
            else if (word == WORD_OUT_ENABLE)
               rsp.read_data = DATA_BITS'(oe_mask);
            else if (chan < CHANNELS)
               rsp.read_data = (word[0] == 1'b0) ? chan_period[chan] : chan_high[chan];
         end
         default: ;
      endcase
      for (int n = 0; n < CHANNELS; n++)
         rsp.pwm_out[n] = gen_mask[n] && oe_mask[n] && (chan_period[n] != '0)
                          && (chan_phase[n] < chan_high[n] || chan_high[n] >= chan_period[n]);
      return rsp;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ADDR_BITS-1:0] chan_address(int unsigned ch, bit is_high,
                                                         logic [1:0] low_bits);
      logic [WORD_BITS-1:0] word;
      word = WORD_CHAN_BASE + WORD_BITS'(2 * ch) + WORD_BITS'(is_high);
      return {word, low_bits};
   endfunction

   task automatic send_request(input logic [KIND_BITS-1:0] kind,
                               input logic [ADDR_BITS-1:0] address,
                               input logic [DATA_BITS-1:0] wdata);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {wdata, address};
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(predict_pwm_response(kind, address, wdata));
   endtask

   task automatic test_register_map();
      send_request(KIND_WRITE, {WORD_GEN_ENABLE, 2'b00}, 32'hFFFF_FFFF);
      send_request(KIND_READ,  {WORD_GEN_ENABLE, 2'b01}, 32'h0);
      send_request(KIND_WRITE, {WORD_OUT_ENABLE, 2'b10}, 32'hAAAA_AA55);
      send_request(KIND_READ,  {WORD_OUT_ENABLE, 2'b11}, 32'hFFFF_FFFF);
      send_request(KIND_WRITE, chan_address(CHANNELS - 1, 1'b0, 2'b11), 32'hFFFF_FFFF);
      send_request(KIND_READ,  chan_address(CHANNELS - 1, 1'b0, 2'b00), 32'h0);
      send_request(KIND_WRITE, chan_address(CHANNELS - 1, 1'b1, 2'b00), 32'h8000_0000);
      send_request(KIND_READ,  chan_address(CHANNELS - 1, 1'b1, 2'b10), 32'h0);
      send_request(KIND_TICK,  8'hFF, 32'h5A5A_5A5A);
      send_request(KIND_WRITE, chan_address(CHANNELS, 1'b0, 2'b00), 32'hDEAD_BEEF);
      send_request(KIND_READ,  chan_address(CHANNELS, 1'b0, 2'b00), 32'h0);
      send_request(KIND_READ,  8'hFF, 32'h0);
      send_request(KIND_UNUSED, {WORD_GEN_ENABLE, 2'b00}, 32'h1234_5678);
      send_request(KIND_WRITE, {WORD_GEN_ENABLE, 2'b00}, 32'h0);
   endtask

   task automatic test_channel_levels();
      send_request(KIND_WRITE, {WORD_OUT_ENABLE, 2'b00}, 32'hFF);
      send_request(KIND_WRITE, chan_address(0, 1'b0, 2'b00), 32'd3);
      send_request(KIND_WRITE, chan_address(0, 1'b1, 2'b00), 32'd1);
      send_request(KIND_WRITE, chan_address(1, 1'b0, 2'b00), 32'd0);
      send_request(KIND_WRITE, chan_address(1, 1'b1, 2'b00), 32'd5);
      send_request(KIND_WRITE, chan_address(2, 1'b0, 2'b00), 32'd2);
      send_request(KIND_WRITE, chan_address(2, 1'b1, 2'b00), 32'd2);
      send_request(KIND_WRITE, {WORD_GEN_ENABLE, 2'b00}, 32'h07);
      repeat (3) send_request(KIND_TICK, 8'h00, 32'h0);
      send_request(KIND_WRITE, chan_address(0, 1'b0, 2'b00), 32'd1);
      send_request(KIND_TICK,  8'h00, 32'h0);
      send_request(KIND_WRITE, {WORD_GEN_ENABLE, 2'b00}, 32'h06);
      send_request(KIND_TICK,  8'h00, 32'h0);
   endtask

   task automatic send_noise();
      send_request(KIND_BITS'($urandom_range(0, 3)), ADDR_BITS'($urandom_range(0, 255)),
                   $urandom);
   endtask

   task automatic send_config_write();
      int unsigned          pick;
      int unsigned          ch;
      logic [DATA_BITS-1:0] value;
      pick = $urandom_range(0, 9);
      ch   = $urandom_range(0, CHANNELS - 1);
      if (pick < 2) begin
         send_request(KIND_WRITE, {WORD_GEN_ENABLE, 2'($urandom)}, $urandom | ($urandom & 32'hFF));
      end else if (pick < 3) begin
         send_request(KIND_WRITE, {WORD_OUT_ENABLE, 2'($urandom)}, $urandom | ($urandom & 32'hFF));
      end else if (pick < 7) begin
         pick = $urandom_range(0, 9);
         if (pick < 8)
            value = $urandom_range(1, 16);
         else if (pick < 9)
            value = '0;
         else
            value = $urandom;
         send_request(KIND_WRITE, chan_address(ch, 1'b0, 2'($urandom)), value);
      end else begin
         value = ($urandom_range(0, 9) < 8) ? DATA_BITS'($urandom_range(0, 18)) : $urandom;
         send_request(KIND_WRITE, chan_address(ch, 1'b1, 2'($urandom)), value);
      end
   endtask

   task automatic test_random_traffic(input int unsigned item_total);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < item_total) begin
         steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) begin
            send_config_write();
            sent++;
         end
         repeat ($urandom_range(0, 2)) begin
            send_request(KIND_READ, {6'($urandom_range(0, 17)), 2'($urandom)}, $urandom);
            sent++;
         end
         burst = $urandom_range(5, 40);
         repeat (burst) begin
            if ($urandom_range(0, 19) == 0) begin
               send_noise();
            end else begin
               send_request(KIND_TICK, ADDR_BITS'($urandom), $urandom);
            end
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   initial begin : drive_rsp_ready
      int unsigned hold;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      pwm_response_type expected_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("unexpected response: rsp_tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            expected_rsp = pending_responses.pop_front();
            if (rsp_tdata[31:0] !== expected_rsp.read_data) begin
               $error("read_data: expected %h, actual %h", expected_rsp.read_data,
                      rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[39:32] !== expected_rsp.pwm_out) begin
               $error("pwm_out: expected %b, actual %b", expected_rsp.pwm_out,
                      rsp_tdata[39:32]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_TICK;
      mismatch_count = 0;
      stall_cycles   = 0;
      steady         = 1'b0;
      gen_mask       = '0;
      oe_mask        = '0;
      for (int n = 0; n < CHANNELS; n++) begin
         chan_period[n] = '0;
         chan_high[n]   = '0;
         chan_phase[n]  = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_register_map();
      test_channel_levels();
      test_random_traffic(1300);

      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
